// ===== hdl/s256c_pkg.sv =====
// s256c_pkg: shared types, constants and SHA-256 mixing functions
// for the block compression engine.
// Depends on nothing; used by every module of the block.
package s256c_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned NUM_VARS = 8;
	localparam int unsigned NUM_ROUNDS = 64;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned CFG_IDX_W = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_VARS-1:0][WORD_W-1:0] hash_t;

	typedef struct packed {
		logic [31:0] message_word;
		logic        first_block;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        last_word;
	} out_word_t;

	// sequencer strobes shared by schedule and round units
	typedef struct packed {
		logic shift_in;
		logic load_vars;
		logic step;
		logic expand;
	} ctl_t;

	localparam hash_t STD_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== hdl/sha256_block_compression_top.sv =====
// sha256_block_compression_top: SHA-256 compression engine top level:
// sequencer, chaining value, initial-hash registers and output buffer.
// Depends on s256c_pkg, s256c_sched, s256c_round.
//
// Usage:
//   msg channel (msg_valid/msg_stall/msg) takes sixteen 32-bit big-endian
//   words per 512-bit block, one per cycle while msg_stall is low. Set
//   first_block on a block's first word to start from init_hash_0..7.
//   After the sixteenth word msg_stall stays high through all 64 rounds and
//   the add step; then the eight chaining words go into the output buffer
//   and the next block may be loaded while they drain.
//   dig channel (dig_valid/dig_stall/dig) delivers the eight words, index
//   0 first, last_word on index 7. The single round unit does one round per
//   cycle. A stalled receiver holds the digest word; if the buffer is still
//   full when the next block finishes its rounds, the engine waits in the
//   add step. Reset loads the standard IV into the chaining value and the
//   init_hash registers and clears the sequencer; configuration writes
//   (cfg_we, cfg_index, cfg_data) take effect at once, indexes above 7 are
//   ignored.
module sha256_block_compression_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [s256c_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                           cfg_data,
	input  logic                                  msg_valid,
	output logic                                  msg_stall,
	input  s256c_pkg::in_word_t                   msg,
	output logic                                  dig_valid,
	input  logic                                  dig_stall,
	output s256c_pkg::out_word_t                  dig
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;

	logic [1:0]       state_q;
	logic [3:0]       word_cnt_q;
	logic [5:0]       round_q;
	logic [2:0]       out_idx_q;
	logic             out_busy_q;
	s256c_pkg::hash_t init_q;
	s256c_pkg::hash_t cv_q;
	s256c_pkg::hash_t dig_q;
	s256c_pkg::hash_t vars;
	s256c_pkg::hash_t sums;
	s256c_pkg::word_t wt;
	s256c_pkg::word_t kt;
	s256c_pkg::ctl_t  ctl;
	logic             in_acc;
	logic             out_acc;
	logic             add_go;

	assign msg_stall = (state_q != ST_LOAD);
	assign in_acc    = msg_valid && !msg_stall;
	assign dig_valid = out_busy_q;
	assign out_acc   = dig_valid && !dig_stall;
	assign add_go    = (state_q == ST_ADD) && !out_busy_q;

	assign ctl.shift_in  = in_acc;
	assign ctl.load_vars = in_acc && (word_cnt_q == 4'd15);
	assign ctl.step      = (state_q == ST_ROUND);
	assign ctl.expand    = (round_q[5:4] != 2'd0);

	assign kt = s256c_pkg::ROUND_K[round_q];

	always_comb begin
		for (int i = 0; i < s256c_pkg::NUM_VARS; i++) begin
			sums[i] = cv_q[i] + vars[i];
		end
	end

	s256c_sched u_sched (
		.clk     (clk),
		.ctl     (ctl),
		.word_in (msg.message_word),
		.wt      (wt)
	);

	s256c_round u_round (
		.clk  (clk),
		.ctl  (ctl),
		.cv   (cv_q),
		.wt   (wt),
		.kt   (kt),
		.vars (vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= s256c_pkg::STD_IV;
		end else if (cfg_we && !cfg_index[s256c_pkg::CFG_IDX_W-1]) begin
			init_q[cfg_index[s256c_pkg::CFG_IDX_W-2:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			word_cnt_q <= '0;
			round_q    <= '0;
			cv_q       <= s256c_pkg::STD_IV;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (word_cnt_q == 4'd0 && msg.first_block) begin
							cv_q <= init_q;
						end
						word_cnt_q <= word_cnt_q + 4'd1;
						if (word_cnt_q == 4'd15) begin
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (add_go) begin
						cv_q    <= sums;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output buffer: shifts one chaining word out per delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else if (add_go) begin
			out_busy_q <= 1'b1;
			out_idx_q  <= '0;
		end else if (out_acc) begin
			out_idx_q <= out_idx_q + 3'd1;
			if (out_idx_q == 3'd7) begin
				out_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_go) begin
			dig_q <= sums;
		end else if (out_acc) begin
			for (int i = 0; i < s256c_pkg::NUM_VARS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	assign dig.digest_word  = dig_q[0];
	assign dig.digest_index = out_idx_q;
	assign dig.last_word    = (out_idx_q == 3'd7);

`ifndef ASSERT_OFF
	a_last_word_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && word_cnt_q == 4'd15) |=> (state_q == ST_ROUND))
		else $error("rounds did not start after the last block word");

	a_round_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (round_q == 6'd0))
		else $error("round count not back at zero outside the rounds");

	a_word_cnt_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (word_cnt_q == 4'd0))
		else $error("word count not at zero while compressing");

	a_add_fills_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		add_go |=> (out_busy_q && out_idx_q == 3'd0 && state_q == ST_LOAD))
		else $error("add step did not fill the output buffer");
`endif

endmodule

// ===== hdl/s256c_sched.sv =====
// s256c_sched: sixteen-word message schedule window as a shift line,
// loaded from the input words and expanded one word per round from round 16 on.
// Depends on s256c_pkg.
module s256c_sched (
	input  logic             clk,
	input  s256c_pkg::ctl_t  ctl,
	input  s256c_pkg::word_t word_in,
	output s256c_pkg::word_t wt
);

	s256c_pkg::word_t sh_q [s256c_pkg::BLOCK_WORDS];
	s256c_pkg::word_t exp_w;

	// sh_q[0] holds W[t-16], sh_q[1] W[t-15], sh_q[9] W[t-7], sh_q[14] W[t-2]
	assign exp_w = s256c_pkg::small_sig1(sh_q[14]) + sh_q[9]
		+ s256c_pkg::small_sig0(sh_q[1]) + sh_q[0];
	assign wt = ctl.expand ? exp_w : sh_q[0];

	always_ff @(posedge clk) begin
		if (ctl.shift_in || ctl.step) begin
			for (int i = 0; i < s256c_pkg::BLOCK_WORDS - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
			sh_q[s256c_pkg::BLOCK_WORDS-1] <= ctl.shift_in ? word_in : wt;
		end
	end

endmodule

// ===== hdl/s256c_round.sv =====
// s256c_round: working variables a..h and the single round unit
// applied once per cycle across all 64 rounds.
// Depends on s256c_pkg.
module s256c_round (
	input  logic             clk,
	input  s256c_pkg::ctl_t  ctl,
	input  s256c_pkg::hash_t cv,
	input  s256c_pkg::word_t wt,
	input  s256c_pkg::word_t kt,
	output s256c_pkg::hash_t vars
);

	s256c_pkg::hash_t wv_q;
	s256c_pkg::word_t t1;
	s256c_pkg::word_t t2;
	s256c_pkg::word_t ch;
	s256c_pkg::word_t maj;

	assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1  = wv_q[7] + s256c_pkg::big_sig1(wv_q[4]) + ch + kt + wt;
	assign t2  = s256c_pkg::big_sig0(wv_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (ctl.load_vars) begin
			wv_q <= cv;
		end else if (ctl.step) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	assign vars = wv_q;

endmodule
